// ----- hw/rtl/unix_seconds_to_date_core_defines.svh -----
// ----------------------------------------------------------------------------
// unix seconds to date core assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_TO_DATE_CORE_DEFINES_SVH
`define UNIX_SECONDS_TO_DATE_CORE_DEFINES_SVH

// plain property
`define USD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("usd assertion failed");

// same-cycle implication
`define USD_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("usd implication failed");

`endif

// ----- hw/rtl/usd_pkg.sv -----
// ----------------------------------------------------------------------------
// usd_pkg
// widths, constants, reciprocals and types of the unix seconds to date core
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int unsigned SECONDS_WIDTH = 40;

  // 86400 = 675 << 7
  localparam int unsigned TOD_LOW_W   = 7;
  localparam int unsigned DAY_SPLIT_W = SECONDS_WIDTH - TOD_LOW_W;
  localparam int unsigned DAYS_W      = SECONDS_WIDTH - 16;

  localparam logic [9:0]        DAY_ODD   = 10'd675;
  localparam logic [DAYS_W-1:0] RECIP_DAY =
    DAYS_W'((64'd1 << DAY_SPLIT_W) / 64'd675);

  localparam logic [17:0] ERA_DIV        = 18'd146097;
  localparam logic [16:0] ERA_OFS        = 17'd102032;
  localparam logic [8:0]  ERA_BIAS       = 9'd15;
  localparam logic [21:0] JD_OFS         = 22'd2442113;
  localparam logic [11:0] YEAR_OFS       = 12'd2442;
  localparam logic [12:0] YEAR_DIV       = 13'd7305;
  localparam logic [9:0]  MONTH_NUM      = 10'd1000;
  localparam logic [14:0] MONTH_DIV      = 15'd30601;
  localparam logic [9:0]  MONTH_FRAC     = 10'd601;
  localparam logic [9:0]  MILLE          = 10'd1000;
  localparam logic [4:0]  MONTH_WRAP     = 5'd13;
  localparam logic [15:0] YEAR_BASE      = 16'd4716;
  localparam logic [15:0] YEAR_BASE_LATE = 16'd4715;

  localparam logic [8:0]  RECIP_ERA   = 9'((32'd1 << 26) / 32'd146097);
  localparam logic [16:0] RECIP_YEAR  = 17'((32'd1 << 29) / 32'd7305);
  localparam logic [5:0]  RECIP_MONTH = 6'((32'd1 << 20) / 32'd30601);
  localparam logic [15:0] MONTH_STEP  = 16'(32'd1000 * 32'(RECIP_MONTH));
  localparam logic [5:0]  RECIP_MILLE = 6'((32'd1 << 15) / 32'd1000);
  localparam logic [14:0] MILLE_STEP  = 15'(32'd601 * 32'(RECIP_MILLE));
  localparam logic [9:0]  RECIP_CENT  = 10'((32'd1 << 16) / 32'd100);
  localparam logic [11:0] RECIP_MIN   = 12'((32'd1 << 17) / 32'd60);
  localparam logic [5:0]  RECIP_HOUR  = 6'((32'd1 << 11) / 32'd60);
  localparam logic [9:0]  RECIP_WEEK  = 10'((32'd1 << 12) / 32'd7);

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // (26 * (month + 1)) / 10
  function automatic logic [5:0] zeller_month(input logic [3:0] month);
    logic [5:0] val;
    case (month)
      4'd0:    val = 6'd2;
      4'd1:    val = 6'd5;
      4'd2:    val = 6'd7;
      4'd3:    val = 6'd10;
      4'd4:    val = 6'd13;
      4'd5:    val = 6'd15;
      4'd6:    val = 6'd18;
      4'd7:    val = 6'd20;
      4'd8:    val = 6'd23;
      4'd9:    val = 6'd26;
      4'd10:   val = 6'd28;
      4'd11:   val = 6'd31;
      4'd12:   val = 6'd33;
      4'd13:   val = 6'd36;
      4'd14:   val = 6'd39;
      default: val = 6'd41;
    endcase
    return val;
  endfunction

endpackage

// ----- hw/rtl/unix_seconds_to_date_core.sv -----
// ----------------------------------------------------------------------------
// unix seconds to date core: time of day, civil date and iso weekday
// one item per cycle while in_stall_o is low, 17-stage constant-division pipeline
// stages advance independently, so bubbles close up under output stall
// reset clears all stage valid bits, data registers are not reset
// ----------------------------------------------------------------------------
`include "unix_seconds_to_date_core_defines.svh"

module unix_seconds_to_date_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [usd_pkg::SECONDS_WIDTH-1:0]  unix_seconds_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [5:0]                         second_of_minute_o,
  output logic [5:0]                         minute_of_hour_o,
  output logic [4:0]                         hour_of_day_o,
  output logic [4:0]                         day_of_month_o,
  output logic [3:0]                         month_of_year_o,
  output logic [15:0]                        year_number_o,
  output logic [2:0]                         weekday_number_o
);

  localparam int unsigned SecW       = usd_pkg::SECONDS_WIDTH;
  localparam int unsigned LowW       = usd_pkg::TOD_LOW_W;
  localparam int unsigned SplitW     = usd_pkg::DAY_SPLIT_W;
  localparam int unsigned DaysW      = usd_pkg::DAYS_W;
  localparam int unsigned SplitProdW = SplitW + DaysW;
  localparam int unsigned NumStages  = 17;
  localparam int unsigned TodStage   = 5;
  localparam int unsigned DateStage  = 11;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] stage_en;

  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      stage_en[i] = !valid_q[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (stage_en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign in_stall_o  = !stage_en[0];
  assign out_valid_o = valid_q[NumStages-1];

  // stage registers
  logic [SplitW-1:0]  s0_split_q;
  logic [LowW-1:0]    s0_low_q;
  logic [DaysW-1:0]   s0_days_q;
  logic [DaysW-1:0]   s1_days_q;
  logic [16:0]        s1_sod_q;
  logic [DaysW-1:0]   s2_days_q;
  logic [25:0]        s2_na_q;
  logic [8:0]         s2_qa_q;
  logic [16:0]        s2_sod_q;
  logic [10:0]        s2_mt_q;
  logic [DaysW-1:0]   s3_days_q;
  logic [8:0]         s3_a_q;
  logic [10:0]        s3_mt_q;
  logic [5:0]         s3_sec_q;
  logic [23:0]        s4_b_q;
  logic [10:0]        s4_mt_q;
  logic [5:0]         s4_sec_q;
  logic [4:0]         s4_hr_q;
  logic [23:0]        s5_b_q;
  logic [28:0]        s5_nc_q;
  logic [15:0]        s5_c_q;
  logic [23:0]        s6_b_q;
  logic [15:0]        s6_c_q;
  logic [9:0]         s7_d_q;
  logic [15:0]        s7_c_q;
  logic [19:0]        s8_nd_q;
  logic [5:0]         s8_e_q;
  logic [9:0]         s8_d_q;
  logic [15:0]        s8_c_q;
  logic [4:0]         s9_e_q;
  logic [9:0]         s9_d_q;
  logic [15:0]        s9_c_q;
  logic [14:0]        s10_ng_q;
  logic [4:0]         s10_g_q;
  logic [4:0]         s10_e_q;
  logic [9:0]         s10_d_q;
  logic [15:0]        s10_c_q;
  logic [15:0]        s12_zc_q;
  logic [3:0]         s12_ze_q;
  logic [9:0]         s12_cent_q;
  logic [9:0]         s13_cent_q;
  logic [6:0]         s13_yoc_q;
  logic [3:0]         s13_ze_q;
  logic [11:0]        s14_h_q;
  logic [11:0]        s15_n7_q;
  logic [9:0]         s15_w_q;
  logic [2:0]         s16_wd_q;
  usd_pkg::tod_t      tod_q  [TodStage:NumStages-1];
  usd_pkg::date_t     date_q [DateStage:NumStages-1];

  // next values
  logic [SplitW-1:0]     s0_split_d;
  logic [SplitProdW-1:0] s0_prod_d;
  logic [SplitW-1:0]     s1_diff_d;
  logic [10:0]           s1_rem_d;
  logic [DaysW-1:0]      s1_days_d;
  logic [9:0]            s1_rem_fix_d;
  logic [25:0]           s2_na_d;
  logic [34:0]           s2_prod_d;
  logic [28:0]           s2_mprod_d;
  logic [25:0]           s3_diff_d;
  logic [18:0]           s3_rem_d;
  logic [8:0]            s3_a_d;
  logic [16:0]           s3_mdiff_d;
  logic [6:0]            s3_mrem_d;
  logic [10:0]           s3_mt_d;
  logic [5:0]            s3_sec_d;
  logic [23:0]           s4_b_d;
  logic [16:0]           s4_hprod_d;
  logic [28:0]           s5_nc_d;
  logic [45:0]           s5_prod_d;
  logic [10:0]           s5_hdiff_d;
  logic [6:0]            s5_hrem_d;
  usd_pkg::tod_t         tod_d;
  logic [28:0]           s6_diff_d;
  logic [13:0]           s6_rem_d;
  logic [15:0]           s6_c_d;
  logic [23:0]           s7_diff_d;
  logic [19:0]           s8_nd_d;
  logic [25:0]           s8_prod_d;
  logic [19:0]           s9_diff_d;
  logic [15:0]           s9_rem_d;
  logic [5:0]            s9_e_d;
  logic [14:0]           s10_ng_d;
  logic [19:0]           s10_prod_d;
  logic [14:0]           s11_gdiff_d;
  logic [10:0]           s11_grem_d;
  logic [4:0]            s11_g_d;
  logic [9:0]            s11_f_d;
  usd_pkg::date_t        date_d;
  logic [15:0]           s12_zc_d;
  logic [3:0]            s12_ze_d;
  logic [25:0]           s12_prod_d;
  logic [15:0]           s13_diff_d;
  logic [7:0]            s13_rem_d;
  logic [9:0]            s13_cent_d;
  logic [6:0]            s13_yoc_d;
  logic [11:0]           s14_h_d;
  logic [11:0]           s15_n7_d;
  logic [21:0]           s15_prod_d;
  logic [11:0]           s16_diff_d;
  logic [3:0]            s16_rem_d;
  logic [2:0]            s16_wd_d;

  always_comb begin
    // split into day count and second of day
    s0_split_d = unix_seconds_i[SecW-1:LowW];
    s0_prod_d  = SplitProdW'(s0_split_d) * SplitProdW'(usd_pkg::RECIP_DAY);

    s1_diff_d = s0_split_q - SplitW'(s0_days_q) * SplitW'(usd_pkg::DAY_ODD);
    s1_rem_d  = s1_diff_d[10:0];
    if (s1_rem_d >= 11'(usd_pkg::DAY_ODD)) begin
      s1_days_d    = s0_days_q + DaysW'(1);
      s1_rem_fix_d = 10'(s1_rem_d - 11'(usd_pkg::DAY_ODD));
    end else begin
      s1_days_d    = s0_days_q;
      s1_rem_fix_d = s1_rem_d[9:0];
    end

    // era term and minute of day
    s2_na_d    = 26'({s1_days_q, 2'b00}) + 26'(usd_pkg::ERA_OFS);
    s2_prod_d  = 35'(s2_na_d) * 35'(usd_pkg::RECIP_ERA);
    s2_mprod_d = 29'(s1_sod_q) * 29'(usd_pkg::RECIP_MIN);

    s3_diff_d = s2_na_q - 26'(s2_qa_q) * 26'(usd_pkg::ERA_DIV);
    s3_rem_d  = s3_diff_d[18:0];
    if (s3_rem_d >= 19'(usd_pkg::ERA_DIV)) begin
      s3_a_d = s2_qa_q + 9'd1 + usd_pkg::ERA_BIAS;
    end else begin
      s3_a_d = s2_qa_q + usd_pkg::ERA_BIAS;
    end
    s3_mdiff_d = s2_sod_q - 17'(s2_mt_q) * 17'd60;
    s3_mrem_d  = s3_mdiff_d[6:0];
    if (s3_mrem_d >= 7'd60) begin
      s3_mt_d  = s2_mt_q + 11'd1;
      s3_sec_d = 6'(s3_mrem_d - 7'd60);
    end else begin
      s3_mt_d  = s2_mt_q;
      s3_sec_d = s3_mrem_d[5:0];
    end

    s4_b_d     = 24'(s3_days_q) + 24'(usd_pkg::JD_OFS) + 24'(s3_a_q) - 24'(s3_a_q[8:2]);
    s4_hprod_d = 17'(s3_mt_q) * 17'(usd_pkg::RECIP_HOUR);

    // year estimate and hour fix
    s5_nc_d   = 29'({s4_b_q, 4'b0000}) + 29'({s4_b_q, 2'b00}) - 29'(usd_pkg::YEAR_OFS);
    s5_prod_d = 46'(s5_nc_d) * 46'(usd_pkg::RECIP_YEAR);
    s5_hdiff_d = s4_mt_q - 11'(s4_hr_q) * 11'd60;
    s5_hrem_d  = s5_hdiff_d[6:0];
    tod_d.second = s4_sec_q;
    if (s5_hrem_d >= 7'd60) begin
      tod_d.hour   = s4_hr_q + 5'd1;
      tod_d.minute = 6'(s5_hrem_d - 7'd60);
    end else begin
      tod_d.hour   = s4_hr_q;
      tod_d.minute = s5_hrem_d[5:0];
    end

    s6_diff_d = s5_nc_q - 29'(s5_c_q) * 29'(usd_pkg::YEAR_DIV);
    s6_rem_d  = s6_diff_d[13:0];
    if (s6_rem_d >= 14'(usd_pkg::YEAR_DIV)) begin
      s6_c_d = s5_c_q + 16'd1;
    end else begin
      s6_c_d = s5_c_q;
    end

    s7_diff_d = s6_b_q - 24'(s6_c_q) * 24'd365 - 24'(s6_c_q[15:2]);

    // month from day of march-based year
    s8_nd_d   = 20'(s7_d_q) * 20'(usd_pkg::MONTH_NUM);
    s8_prod_d = 26'(s7_d_q) * 26'(usd_pkg::MONTH_STEP);

    s9_diff_d = s8_nd_q - 20'(s8_e_q) * 20'(usd_pkg::MONTH_DIV);
    s9_rem_d  = s9_diff_d[15:0];
    if (s9_rem_d >= 16'(usd_pkg::MONTH_DIV)) begin
      s9_e_d = s8_e_q + 6'd1;
    end else begin
      s9_e_d = s8_e_q;
    end

    s10_ng_d   = 15'(s9_e_q) * 15'(usd_pkg::MONTH_FRAC);
    s10_prod_d = 20'(s9_e_q) * 20'(usd_pkg::MILLE_STEP);

    s11_gdiff_d = s10_ng_q - 15'(s10_g_q) * 15'(usd_pkg::MILLE);
    s11_grem_d  = s11_gdiff_d[10:0];
    if (s11_grem_d >= 11'(usd_pkg::MILLE)) begin
      s11_g_d = s10_g_q + 5'd1;
    end else begin
      s11_g_d = s10_g_q;
    end
    s11_f_d    = s10_d_q - 10'(s10_e_q) * 10'd30 - 10'(s11_g_d);
    date_d.day = s11_f_d[4:0];
    if (s10_e_q <= usd_pkg::MONTH_WRAP) begin
      date_d.year  = s10_c_q - usd_pkg::YEAR_BASE;
      date_d.month = 4'(s10_e_q - 5'd1);
    end else begin
      date_d.year  = s10_c_q - usd_pkg::YEAR_BASE_LATE;
      date_d.month = 4'(s10_e_q - usd_pkg::MONTH_WRAP);
    end

    // weekday, january and february count in the prior year
    if (date_q[DateStage].month <= 4'd2) begin
      s12_ze_d = date_q[DateStage].month + 4'd12;
      s12_zc_d = date_q[DateStage].year - 16'd1;
    end else begin
      s12_ze_d = date_q[DateStage].month;
      s12_zc_d = date_q[DateStage].year;
    end
    s12_prod_d = 26'(s12_zc_d) * 26'(usd_pkg::RECIP_CENT);

    s13_diff_d = s12_zc_q - 16'(s12_cent_q) * 16'd100;
    s13_rem_d  = s13_diff_d[7:0];
    if (s13_rem_d >= 8'd100) begin
      s13_cent_d = s12_cent_q + 10'd1;
      s13_yoc_d  = 7'(s13_rem_d - 8'd100);
    end else begin
      s13_cent_d = s12_cent_q;
      s13_yoc_d  = s13_rem_d[6:0];
    end

    s14_h_d = 12'(date_q[DateStage+2].day) + 12'(usd_pkg::zeller_month(s13_ze_q))
            + 12'(s13_yoc_q) + 12'(s13_yoc_q[6:2])
            + 12'(s13_cent_q) * 12'd5 + 12'(s13_cent_q[9:2]);

    s15_n7_d   = s14_h_q + 12'd5;
    s15_prod_d = 22'(s15_n7_d) * 22'(usd_pkg::RECIP_WEEK);

    s16_diff_d = s15_n7_q - 12'(s15_w_q) * 12'd7;
    s16_rem_d  = s16_diff_d[3:0];
    if (s16_rem_d >= 4'd7) begin
      s16_wd_d = 3'(s16_rem_d - 4'd7) + 3'd1;
    end else begin
      s16_wd_d = s16_rem_d[2:0] + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s0_split_q <= s0_split_d;
      s0_low_q   <= unix_seconds_i[LowW-1:0];
      s0_days_q  <= s0_prod_d[SplitW +: DaysW];
    end
    if (stage_en[1]) begin
      s1_days_q <= s1_days_d;
      s1_sod_q  <= {s1_rem_fix_d, s0_low_q};
    end
    if (stage_en[2]) begin
      s2_days_q <= s1_days_q;
      s2_na_q   <= s2_na_d;
      s2_qa_q   <= s2_prod_d[26 +: 9];
      s2_sod_q  <= s1_sod_q;
      s2_mt_q   <= s2_mprod_d[17 +: 11];
    end
    if (stage_en[3]) begin
      s3_days_q <= s2_days_q;
      s3_a_q    <= s3_a_d;
      s3_mt_q   <= s3_mt_d;
      s3_sec_q  <= s3_sec_d;
    end
    if (stage_en[4]) begin
      s4_b_q   <= s4_b_d;
      s4_mt_q  <= s3_mt_q;
      s4_sec_q <= s3_sec_q;
      s4_hr_q  <= s4_hprod_d[11 +: 5];
    end
    if (stage_en[5]) begin
      s5_b_q  <= s4_b_q;
      s5_nc_q <= s5_nc_d;
      s5_c_q  <= s5_prod_d[29 +: 16];
    end
    if (stage_en[6]) begin
      s6_b_q <= s5_b_q;
      s6_c_q <= s6_c_d;
    end
    if (stage_en[7]) begin
      s7_d_q <= s7_diff_d[9:0];
      s7_c_q <= s6_c_q;
    end
    if (stage_en[8]) begin
      s8_nd_q <= s8_nd_d;
      s8_e_q  <= s8_prod_d[20 +: 6];
      s8_d_q  <= s7_d_q;
      s8_c_q  <= s7_c_q;
    end
    if (stage_en[9]) begin
      s9_e_q <= s9_e_d[4:0];
      s9_d_q <= s8_d_q;
      s9_c_q <= s8_c_q;
    end
    if (stage_en[10]) begin
      s10_ng_q <= s10_ng_d;
      s10_g_q  <= s10_prod_d[15 +: 5];
      s10_e_q  <= s9_e_q;
      s10_d_q  <= s9_d_q;
      s10_c_q  <= s9_c_q;
    end
    if (stage_en[12]) begin
      s12_zc_q   <= s12_zc_d;
      s12_ze_q   <= s12_ze_d;
      s12_cent_q <= s12_prod_d[16 +: 10];
    end
    if (stage_en[13]) begin
      s13_cent_q <= s13_cent_d;
      s13_yoc_q  <= s13_yoc_d;
      s13_ze_q   <= s12_ze_q;
    end
    if (stage_en[14]) begin
      s14_h_q <= s14_h_d;
    end
    if (stage_en[15]) begin
      s15_n7_q <= s15_n7_d;
      s15_w_q  <= s15_prod_d[12 +: 10];
    end
    if (stage_en[16]) begin
      s16_wd_q <= s16_wd_d;
    end
  end

  // time of day and date ride along to the output stage
  always_ff @(posedge clk_i) begin
    if (stage_en[TodStage]) begin
      tod_q[TodStage] <= tod_d;
    end
    for (int i = TodStage + 1; i < NumStages; i++) begin
      if (stage_en[i]) begin
        tod_q[i] <= tod_q[i-1];
      end
    end
    if (stage_en[DateStage]) begin
      date_q[DateStage] <= date_d;
    end
    for (int i = DateStage + 1; i < NumStages; i++) begin
      if (stage_en[i]) begin
        date_q[i] <= date_q[i-1];
      end
    end
  end

  assign second_of_minute_o = tod_q[NumStages-1].second;
  assign minute_of_hour_o   = tod_q[NumStages-1].minute;
  assign hour_of_day_o      = tod_q[NumStages-1].hour;
  assign day_of_month_o     = date_q[NumStages-1].day;
  assign month_of_year_o    = date_q[NumStages-1].month;
  assign year_number_o      = date_q[NumStages-1].year;
  assign weekday_number_o   = s16_wd_q;

  `USD_ASSERT_IMPL(a_stall_only_when_full, in_stall_o, (&valid_q) && out_stall_i)
  `USD_ASSERT(a_out_advance, (!out_stall_i && valid_q[NumStages-2]) |=> out_valid_o)
  `USD_ASSERT_IMPL(a_time_range, out_valid_o, (second_of_minute_o < 6'd60) && (minute_of_hour_o < 6'd60) && (hour_of_day_o < 5'd24))
  `USD_ASSERT_IMPL(a_date_range, out_valid_o, (month_of_year_o >= 4'd1) && (month_of_year_o <= 4'd12) && (day_of_month_o >= 5'd1) && (weekday_number_o >= 3'd1))

endmodule
